FILE: hw/rtl/b64fe_pkg.sv
// shared types and constants for the filename-safe base64 encoder
// no dependencies; imported by every module of the block
`default_nettype none

package b64fe_pkg;

    localparam int unsigned SizeWidth = 12;
    localparam int unsigned SixWidth  = 6;
    localparam int unsigned CharWidth = 7;
    localparam int unsigned MaxRes    = 3;

    localparam logic [SizeWidth-1:0] SizeReset = 12'd4095;
    localparam logic [CharWidth-1:0] CharNul   = 7'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [CharWidth-1:0] out_char;
        logic                 end_mark;
    } t_out_item;

    // one classified byte: its results in order, slot 0 first
    typedef struct packed {
        t_out_item [MaxRes-1:0] res;
        logic      [1:0]        count;
    } t_entry;

    // queue head as seen by the back end
    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    // six-bit code to its alphabet character
    function automatic logic [CharWidth-1:0] six_to_char(input logic [SixWidth-1:0] six);
        logic [CharWidth-1:0] v;
        begin
            v = {1'b0, six};
            if (six < 6'd26) begin
                six_to_char = v + 7'd65;
            end else if (six < 6'd52) begin
                six_to_char = v + 7'd71;
            end else if (six < 6'd62) begin
                six_to_char = v - 7'd4;
            end else if (six == 6'd62) begin
                six_to_char = 7'd43;
            end else begin
                six_to_char = 7'd95;
            end
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b64fe_front.sv
// front end: takes bytes, tracks group phase and character budget,
// and builds one queue entry per byte; uses b64fe_pkg
`default_nettype none

module b64fe_front
    import b64fe_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    input  wire logic [SizeWidth-1:0] i_budget,
    input  wire logic                 i_q_ready,
    output logic                      o_q_push,
    output t_entry                    o_q_entry
);

    logic [1:0]           r_phase, n_phase;
    logic [3:0]           r_left, n_left;
    logic [SizeWidth-1:0] r_count, n_count;

    logic [SixWidth-1:0] six0, six1;
    logic [3:0]          left_next;
    logic                two_chars;
    logic                ok0, ok1;
    logic [1:0]          k;
    logic [SizeWidth:0]  cnt_ext;
    logic [7:0]          b;
    logic                last;
    t_out_item           item0, item1, item_end;

    assign b          = i_in_data.data_byte;
    assign last       = i_in_data.last_byte;
    assign o_in_ready = i_q_ready;
    assign o_q_push   = i_in_valid && i_q_ready;

    always_comb begin
        unique case (r_phase)
            2'd1: begin
                six0      = {r_left[1:0], b[7:4]};
                six1      = {b[3:0], 2'b00};
                left_next = b[3:0];
                two_chars = last;
            end
            2'd2: begin
                six0      = {r_left, b[7:6]};
                six1      = b[5:0];
                left_next = 4'd0;
                two_chars = 1'b1;
            end
            default: begin
                six0      = b[7:2];
                six1      = {b[1:0], 4'b0000};
                left_next = {2'b00, b[1:0]};
                two_chars = last;
            end
        endcase
    end

    // budget check for the one or two characters of this byte
    assign cnt_ext = {1'b0, r_count};
    assign ok0     = cnt_ext < {1'b0, i_budget};
    assign ok1     = (cnt_ext + 13'd1) < {1'b0, i_budget};

    always_comb begin
        if (!ok0) begin
            k = 2'd0;
        end else if (two_chars && ok1) begin
            k = 2'd2;
        end else begin
            k = 2'd1;
        end
    end

    always_comb begin
        item0.out_char    = six_to_char(six0);
        item0.end_mark    = 1'b0;
        item1.out_char    = six_to_char(six1);
        item1.end_mark    = 1'b0;
        item_end.out_char = CharNul;
        item_end.end_mark = 1'b1;

        o_q_entry.res[0] = (k == 2'd0) ? item_end : item0;
        o_q_entry.res[1] = (k == 2'd1) ? item_end : item1;
        o_q_entry.res[2] = item_end;
        o_q_entry.count  = k + {1'b0, last};
    end

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_count = r_count;
        if (o_q_push) begin
            if (last) begin
                n_phase = 2'd0;
                n_left  = 4'd0;
                n_count = '0;
            end else begin
                n_phase = (r_phase == 2'd1) ? 2'd2 : ((r_phase == 2'd2) ? 2'd0 : 2'd1);
                n_left  = left_next;
                n_count = r_count + {{(SizeWidth-2){1'b0}}, k};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_left  <= 4'd0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/b64fe_queue.sv
// short queue of classified entries between front and back end
// uses b64fe_pkg for the entry type
`default_nettype none

module b64fe_queue
    import b64fe_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_ready,
    input  wire logic   i_pop,
    output t_head       o_head
);

    localparam int unsigned PtrWidth = $clog2(DEPTH);
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

    t_entry r_mem [DEPTH];
    logic [PtrWidth-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrWidth-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntWidth-1:0] r_fill, n_fill;
    logic                do_pop;

    assign o_ready      = r_fill != CntFull;
    assign o_head.valid = r_fill != '0;
    assign o_head.entry = r_mem[r_rd_ptr];
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!i_push && do_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/b64fe_back.sv
// back end: walks the results of the queue head into the output register
// one per cycle while that register can load; uses b64fe_pkg
`default_nettype none

module b64fe_back
    import b64fe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_head i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_out_item  o_out_data
);

    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out;
    t_out_item  sel;
    logic       can_load;
    logic       empty_entry;
    logic       last_slot;

    assign can_load    = !r_out_valid || i_out_ready;
    assign empty_entry = i_head.entry.count == 2'd0;
    assign last_slot   = r_idx == (i_head.entry.count - 2'd1);
    // an entry with no results (budget spent) is popped without sending anything
    assign o_pop       = i_head.valid && can_load && (empty_entry || last_slot);

    always_comb begin
        case (r_idx)
            2'd1:    sel = i_head.entry.res[1];
            2'd2:    sel = i_head.entry.res[2];
            default: sel = i_head.entry.res[0];
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (can_load) begin
            n_out_valid = i_head.valid && !empty_entry;
            if (o_pop) begin
                n_idx = 2'd0;
            end else if (i_head.valid) begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            r_out <= sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: hw/rtl/base64_filename_encoder.sv
// Filename-safe base64 encoder (A-Z a-z 0-9 + _), unpadded, one byte per
// input transaction. A byte is taken whenever the entry queue has room;
// the front end turns it into its 0 to 3 results (characters, plus the
// closing NUL with end_mark after the byte flagged last_byte) and the back
// end sends them out one per cycle, while the receiver is ready, through a
// registered output, which sets the throughput; a string gives 4 characters
// per 3 bytes in steady state. A byte whose characters fall past the budget
// still passes through the back end. At most buffer_size-1 characters are
// sent per string (none when buffer_size is 0); the NUL is always sent.
// Write the buffer size only while the block is idle.
// depends on b64fe_pkg, b64fe_front, b64fe_queue and b64fe_back
`default_nettype none

module base64_filename_encoder
    import b64fe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [SizeWidth-1:0] i_cfg_data
);

    logic [SizeWidth-1:0] r_buffer_size;
    logic [SizeWidth-1:0] budget;
    logic                 q_ready;
    logic                 q_push;
    logic                 q_pop;
    t_entry               q_entry;
    t_head                q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= SizeReset;
        end else if (i_cfg_valid) begin
            r_buffer_size <= i_cfg_data;
        end
    end

    assign budget = (r_buffer_size == '0) ? '0 : r_buffer_size - 1'b1;

    b64fe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_budget   (budget),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_entry  (q_entry)
    );

    b64fe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    b64fe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: dv/base64_filename_encoder_tb.sv
// testbench for base64_filename_encoder: drives byte transactions and buffer size writes,
// predicts every encoded character and closing NUL, and checks them as they arrive
// depends on b64fe_pkg and the encoder rtl
module base64_filename_encoder_tb;
    import b64fe_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 200000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned LONG_HOLD     = 80;

    // predicts the encoder output and compares each output transaction against it
    class char_scoreboard;
        localparam logic [8*64-1:0] ALPHABET =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+_";

        t_out_item            expected_chars[$];
        logic [SizeWidth-1:0] buf_size;
        logic [1:0]           group_pos;
        logic [3:0]           carry_bits;
        logic [SizeWidth-1:0] sent_count;
        int                   n_errors;

        function new();
            buf_size   = SizeReset;
            group_pos  = 2'd0;
            carry_bits = 4'd0;
            sent_count = '0;
            n_errors   = 0;
        endfunction

        function void set_size(logic [SizeWidth-1:0] size);
            buf_size = size;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        // queue one character unless the budget is used up
        function void push_six(logic [5:0] six);
            logic [SizeWidth-1:0] budget;
            logic [7:0]           code;
            t_out_item            item;
            budget = (buf_size == '0) ? '0 : buf_size - 1'b1;
            if (sent_count < budget) begin
                code          = ALPHABET[8*(63-six) +: 8];
                item.out_char = code[CharWidth-1:0];
                item.end_mark = 1'b0;
                expected_chars.push_back(item);
                sent_count = sent_count + 1'b1;
            end
        endfunction

        function void note_byte(t_in_item it);
            logic [7:0] b;
            t_out_item  nul;
            b = it.data_byte;
            case (group_pos)
                2'd1: begin
                    push_six({carry_bits[1:0], b[7:4]});
                    carry_bits = b[3:0];
                    group_pos  = 2'd2;
                    if (it.last_byte) begin
                        push_six({carry_bits, 2'b00});
                    end
                end
                2'd2: begin
                    push_six({carry_bits, b[7:6]});
                    push_six(b[5:0]);
                    carry_bits = 4'd0;
                    group_pos  = 2'd0;
                end
                default: begin
                    push_six(b[7:2]);
                    carry_bits = {2'b00, b[1:0]};
                    group_pos  = 2'd1;
                    if (it.last_byte) begin
                        push_six({b[1:0], 4'b0000});
                    end
                end
            endcase
            if (it.last_byte) begin
                nul.out_char = CharNul;
                nul.end_mark = 1'b1;
                expected_chars.push_back(nul);
                group_pos  = 2'd0;
                carry_bits = 4'd0;
                sent_count = '0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            n_errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected result char=%0d end=%0b",
                                          got.out_char, got.end_mark));
            end else begin
                want = expected_chars.pop_front();
                if (got.out_char !== want.out_char) begin
                    report_mismatch($sformatf("out_char got %0d want %0d",
                                              got.out_char, want.out_char));
                end
                if (got.end_mark !== want.end_mark) begin
                    report_mismatch($sformatf("end_mark got %0b want %0b (char %0d)",
                                              got.end_mark, want.end_mark, want.out_char));
                end
            end
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_data   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [SizeWidth-1:0] i_cfg_data  = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_item            o_out_data;
    logic                 o_cfg_ready;

    char_scoreboard sb;
    bit             quiet_mode = 1'b0;
    bit             hold_req   = 1'b0;

    base64_filename_encoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic last);
        int       gap;
        t_in_item it;
        it.data_byte = data;
        it.last_byte = last;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_byte(it);
    endtask

    task automatic write_size(input logic [SizeWidth-1:0] size);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_size(size);
    endtask

    // bytes past the budget leave no result, so let the pipeline settle too
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random strings; leave_open ends the batch in the middle of a string
    task automatic send_strings(input int n_items, input bit leave_open);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
            if (len > left) begin
                len = left;
            end
            for (int k = 0; k < len; k++) begin
                send_byte(8'($urandom_range(0, 255)),
                          (k == len - 1) && !(leave_open && left == len));
            end
            left -= len;
        end
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) begin
                sb.check_result(o_out_data);
            end
            if (stall_left == 0) begin
                if (hold_req) begin
                    hold_req   = 1'b0;
                    stall_left = LONG_HOLD;
                end else begin
                    stall_left = pick_gap();
                end
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset buffer size: whole groups, both partial endings, '+' and '_'
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hBF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();

        // zero size: only the NUL survives
        write_size('0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);
        wait_idle();

        write_size(12'd1);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b1);
        wait_idle();

        // budget runs out partway through the string
        write_size(12'd2);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h0F, 1'b1);
        wait_idle();

        write_size(12'd5);
        send_strings(22, 1'b1);
        wait_idle();

        // new budget lands mid-string; receiver holds off so the input stalls
        write_size(12'd9);
        hold_req = 1'b1;
        send_strings(22, 1'b0);
        wait_idle();

        write_size(SizeWidth'($urandom_range(1, 24)));
        quiet_mode = 1'b1;
        send_strings(22, 1'b0);
        quiet_mode = 1'b0;
        wait_idle();

        write_size(SizeReset);
        send_strings(22, 1'b0);
        wait_idle();

        write_size(12'd3);
        send_strings(11, 1'b0);
        wait_idle();

        write_size(SizeWidth'($urandom_range(0, 40)));
        send_strings(11, 1'b0);
        wait_idle();

        if (sb.n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 10);
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/b64fe_pkg.sv
hw/rtl/b64fe_front.sv
hw/rtl/b64fe_queue.sv
hw/rtl/b64fe_back.sv
hw/rtl/base64_filename_encoder.sv
dv/base64_filename_encoder_tb.sv
